>>> rtl/core/rdsa_pkg.sv
// Shared types, constants and the glyph lookup for the RGB decimate Sobel ASCII block.
package rdsa_pkg;

	localparam int MAX_HALF_WIDTH_DEF = 32;
	localparam int CFG_W              = 7;
	localparam int PIX_W              = 8;
	localparam int HEIGHT_MAX         = 64;
	localparam int HEIGHT_MIN         = 2;
	localparam int WIDTH_MIN          = 2;

	// Register word addresses (paddr[2]).
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;

	// Position of a kept pixel in the half-size image.
	typedef struct packed {
		logic       keep;   // pixel lies at an even row and even column inside the doubled half size
		logic       last;   // lower-right pixel of the half-size image
		logic [5:0] c;
		logic [4:0] r;
	} pos_t;

	// One line store entry: the two most recent half-size rows at a column.
	typedef struct packed {
		logic [PIX_W-1:0] newer;
		logic [PIX_W-1:0] older;
	} line_t;

	function automatic logic [6:0] glyph(input logic [3:0] idx);
		logic [6:0] g;
		unique case (idx)
			4'd0:  g = 7'd32;
			4'd1:  g = 7'd46;
			4'd2:  g = 7'd59;
			4'd3:  g = 7'd42;
			4'd4:  g = 7'd115;
			4'd5:  g = 7'd116;
			4'd6:  g = 7'd73;
			4'd7:  g = 7'd40;
			4'd8:  g = 7'd106;
			4'd9:  g = 7'd117;
			4'd10: g = 7'd86;
			4'd11: g = 7'd119;
			4'd12: g = 7'd98;
			4'd13: g = 7'd82;
			4'd14: g = 7'd103;
			4'd15: g = 7'd64;
			default: g = 7'd32;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/core/rdsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rdsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> rtl/core/rdsa_raster.sv
// Raster position tracking, size clamping and decimation decode.
module rdsa_raster #(
	parameter int MAX_HALF_WIDTH = rdsa_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rdsa_pkg::CFG_W-1:0] image_width,
	input  logic [rdsa_pkg::CFG_W-1:0] image_height,
	input  logic                     restart,
	input  logic                     advance,
	output rdsa_pkg::pos_t           pos
);
	import rdsa_pkg::*;

	localparam int WCAP = (2 * MAX_HALF_WIDTH < 127) ? 2 * MAX_HALF_WIDTH : 127;

	logic [CFG_W-1:0] w_eff, h_eff;
	logic [CFG_W-1:0] col_q, row_q;
	logic [CFG_W-1:0] col_nxt, row_nxt;
	logic [5:0]       hw, hh;

	always_comb begin
		if (image_width < CFG_W'(WIDTH_MIN)) begin
			w_eff = CFG_W'(WIDTH_MIN);
		end else if (image_width > CFG_W'(WCAP)) begin
			w_eff = CFG_W'(WCAP);
		end else begin
			w_eff = image_width;
		end
		if (image_height < CFG_W'(HEIGHT_MIN)) begin
			h_eff = CFG_W'(HEIGHT_MIN);
		end else if (image_height > CFG_W'(HEIGHT_MAX)) begin
			h_eff = CFG_W'(HEIGHT_MAX);
		end else begin
			h_eff = image_height;
		end
	end

	assign hw = w_eff[6:1];
	assign hh = h_eff[6:1];

	// An odd last column or row falls outside the doubled half size.
	always_comb begin
		pos.keep = !col_q[0] && !row_q[0] && (col_q < {hw, 1'b0}) && (row_q < {hh, 1'b0});
		pos.c    = col_q[6:1];
		pos.r    = row_q[5:1];
		pos.last = (col_q[6:1] == hw - 6'd1) && (row_q[6:1] == hh - 6'd1);
	end

	always_comb begin
		col_nxt = col_q + 7'd1;
		row_nxt = row_q;
		if (col_nxt >= w_eff) begin
			col_nxt = '0;
			row_nxt = row_q + 7'd1;
			if (row_nxt >= h_eff) begin
				row_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end
endmodule

>>> rtl/core/rdsa_kernel.sv
// Column window, 3x3 Sobel arithmetic, glyph lookup and the output register.
module rdsa_kernel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_valid,
	input  rdsa_pkg::pos_t               pos_s1,
	input  logic [rdsa_pkg::PIX_W-1:0]   gray_s1,
	input  rdsa_pkg::line_t              line_rd,
	output logic                         s1_adv,
	output logic [31:0]                  m_axis_tdata,   // symbol[6:0], edge_level[14:7], out_col[19:15], out_row[24:20]
	output logic                         m_axis_tlast,   // frame_end
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready
);
	import rdsa_pkg::*;

	logic [PIX_W-1:0] win_q [6];
	logic signed [11:0] gx, gy;
	logic [10:0]        mag;
	logic [7:0]         lvl;
	logic               emit;

	logic [6:0] sym_q;
	logic [7:0] lvl_q;
	logic [4:0] col_q, row_q;
	logic       end_q;

	assign s1_adv = s1_valid && (!m_axis_tvalid || m_axis_tready);
	assign emit   = pos_s1.keep && (pos_s1.r >= 5'd2) && (pos_s1.c >= 6'd2);

	always_comb begin
		gx = 12'(signed'({4'b0, win_q[0]})) - 12'(signed'({4'b0, line_rd.older}))
		   + 12'(signed'({3'b0, win_q[1], 1'b0})) - 12'(signed'({3'b0, line_rd.newer, 1'b0}))
		   + 12'(signed'({4'b0, win_q[2]})) - 12'(signed'({4'b0, gray_s1}));
		gy = 12'(signed'({4'b0, win_q[0]})) + 12'(signed'({3'b0, win_q[3], 1'b0}))
		   + 12'(signed'({4'b0, line_rd.older})) - 12'(signed'({4'b0, win_q[2]}))
		   - 12'(signed'({3'b0, win_q[5], 1'b0})) - 12'(signed'({4'b0, gray_s1}));
		mag = 11'(gx[11] ? -gx : gx) + 11'(gy[11] ? -gy : gy);
		lvl = mag[10:3];
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.keep) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= line_rd.older;
			win_q[4] <= line_rd.newer;
			win_q[5] <= gray_s1;
		end
		if (s1_adv && emit) begin
			sym_q <= glyph(lvl[3:0]);
			lvl_q <= lvl;
			col_q <= 5'(pos_s1.c - 6'd1);
			row_q <= pos_s1.r - 5'd1;
			end_q <= pos_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s1_adv) begin
			m_axis_tvalid <= emit;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	assign m_axis_tdata = {7'b0, row_q, col_q, lvl_q, sym_q};
	assign m_axis_tlast = end_q;
endmodule

>>> rtl/core/rgb_decimate_sobel_ascii.sv
// Top level: configuration registers, front stage, line store and Sobel kernel.
// Path: the pixel that completes a neighborhood is registered in stage one, and its result
// in the output register that offers it on the master side. Throughput: one pixel per clock
// while the master side does not stall, set by the single line store read and write per kept pixel.
// Reset: width and height return to 32, the raster position to zero and all valid
// flags clear; the line store and column window are not cleared.
module rgb_decimate_sobel_ascii #(
	parameter int MAX_HALF_WIDTH = rdsa_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	output logic [31:0] m_axis_tdata,   // symbol[6:0], edge_level[14:7], out_col[19:15], out_row[24:20]
	output logic        m_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready
);
	import rdsa_pkg::*;

	localparam int AW = $clog2(MAX_HALF_WIDTH);

	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr, accept, s1_adv;
	pos_t             pos, pos_s1;
	logic             s1_valid;
	logic [PIX_W-1:0] gray, gray_s1;
	logic [9:0]       sum;
	line_t            line_rd, line_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = {25'b0, width_q};
			REG_IMAGE_HEIGHT: prdata = {25'b0, height_q};
			default:          prdata = '0;
		endcase
	end

	assign s_axis_tready = !s1_valid || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign sum  = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8]) + 10'(s_axis_tdata[23:16]);
	assign gray = sum[8:1];

	rdsa_raster #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (width_q),
		.image_height(height_q),
		.restart     (cfg_wr),
		.advance     (accept),
		.pos         (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos;
			gray_s1 <= gray;
		end
	end

	// Each entry holds the two latest rows at one column. Reads of one column are at
	// least four pixels apart, so the write back from stage one never races a read.
	assign line_wr.newer = gray_s1;
	assign line_wr.older = line_rd.newer;

	rdsa_ram #(
		.WIDTH($bits(line_t)),
		.DEPTH(MAX_HALF_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (s1_adv && pos_s1.keep),
		.waddr(AW'(pos_s1.c)),
		.wdata(line_wr),
		.re   (accept && pos.keep),
		.raddr(AW'(pos.c)),
		.rdata(line_rd)
	);

	rdsa_kernel u_kernel (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.pos_s1       (pos_s1),
		.gray_s1      (gray_s1),
		.line_rd      (line_rd),
		.s1_adv       (s1_adv),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);
endmodule
